// ===== rtl/core/ptts_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic task tick scheduler package
// Shared constants, command and result codes, and sequencer state type.
// ----------------------------------------------------------------------------
package ptts_pkg;

   localparam int MAX_TASKS_DEF = 16;
   localparam int FIRE_LIMIT    = 16;
   localparam int FIRE_CNT_W    = 5;
   localparam int CMD_W         = 4;
   localparam int KIND_W        = 2;
   localparam int HANDLE_W      = 4;
   localparam int TIME_W        = 32;
   localparam int RATE_W        = 20;
   localparam int DATA_W        = 40;
   localparam int DIV_CNT_W     = 5;

   localparam logic [RATE_W-1:0] RATE_RESET = 20'd1000;
   localparam logic [TIME_W-1:0] MS_SCALE   = 32'd1000;
   localparam logic [TIME_W-1:0] US_SCALE   = 32'd1000000;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK      = 4'd0,
      CMD_PUSH      = 4'd1,
      CMD_PUSH_EN   = 4'd2,
      CMD_POP       = 4'd3,
      CMD_START     = 4'd4,
      CMD_STOP      = 4'd5,
      CMD_TOGGLE    = 4'd6,
      CMD_SET_INT   = 4'd7,
      CMD_SET_RAW   = 4'd8,
      CMD_READ_RAW  = 4'd9,
      CMD_READ_MS   = 4'd10,
      CMD_READ_US   = 4'd11
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_FIRED  = 2'd0,
      KIND_HANDLE = 2'd1,
      KIND_TIME   = 2'd2,
      KIND_FULL   = 2'd3
   } kind_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_MUL   = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

endpackage

// ===== rtl/core/periodic_task_tick_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// Periodic task tick scheduler
// Tick counter with a stack of periodic task slots, fire scan and time reads.
// ----------------------------------------------------------------------------
// The block takes one command beat at a time and is ready again only when all
// result beats of that command have been moved into the output register. A
// tick beat with no slot in use ends in idle; otherwise a single compare unit
// walks the slot memories one entry per cycle, unless a fire is held for a busy
// result register, up to the last slot in use or FIRE_LIMIT fires, then a
// flush state; each fire beyond the first also waits for the result register
// to drain. A millisecond or microsecond read runs the shared restoring
// divider, then the multiply state, then the result beat. Other commands end
// in idle or pass through the flush state.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_unit #(
   parameter int MAX_TASKS = ptts_pkg::MAX_TASKS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // task_index [3:0], value [35:4], zero [39:36].
   input  logic [ptts_pkg::DATA_W-1:0]   req_tdata,
   // cmd [3:0].
   input  logic [ptts_pkg::CMD_W-1:0]    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // task_index_res [3:0], time_value [35:4], zero [39:36].
   output logic [ptts_pkg::DATA_W-1:0]   rsp_tdata,
   // kind [1:0].
   output logic [ptts_pkg::KIND_W-1:0]   rsp_tuser,
   output logic                          rsp_tlast,
   input  logic                          csr_wr_en,
   input  logic [ptts_pkg::RATE_W-1:0]   csr_wr_data
);

   import ptts_pkg::*;

   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int UW = $clog2(MAX_TASKS + 1);

   state_type                 state_ff, state_in;
   logic [TIME_W-1:0]         tick_ff, tick_in;
   logic [UW-1:0]             used_ff, used_in;
   logic [MAX_TASKS-1:0]      en_ff, en_in;
   logic [MAX_TASKS-1:0]      ivld_ff, ivld_in;
   logic [MAX_TASKS-1:0]      lvld_ff, lvld_in;
   logic [RATE_W-1:0]         rate_ff, rate_in;
   logic [IW-1:0]             scan_ff, scan_in;
   logic [FIRE_CNT_W-1:0]     fcnt_ff, fcnt_in;

   logic [TIME_W-1:0]         int_mem [MAX_TASKS];
   logic [TIME_W-1:0]         last_mem [MAX_TASKS];
   logic [TIME_W-1:0]         rd_int_ff, rd_last_ff;
   logic                      rd_ivld_ff, rd_lvld_ff;

   logic [RATE_W:0]           div_rem_ff, div_rem_in;
   logic [TIME_W-1:0]         div_quo_ff, div_quo_in;
   logic [DIV_CNT_W-1:0]      div_cnt_ff, div_cnt_in;
   logic                      div_us_ff, div_us_in;

   logic                      pend_valid_ff, pend_valid_in;
   logic [KIND_W-1:0]         pend_kind_ff, pend_kind_in;
   logic [HANDLE_W-1:0]       pend_idx_ff, pend_idx_in;
   logic [TIME_W-1:0]         pend_time_ff, pend_time_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]         rsp_kind_ff;
   logic [HANDLE_W-1:0]       rsp_idx_ff;
   logic [TIME_W-1:0]         rsp_time_ff;
   logic                      rsp_last_ff;

   logic                      accept, out_free, out_load, out_last;
   logic                      rd_en, iw_en, lw_en;
   logic [IW-1:0]             rd_addr, iw_addr, lw_addr;
   logic [HANDLE_W-1:0]       req_idx;
   logic [TIME_W-1:0]         req_value;
   logic [IW+HANDLE_W-1:0]    idx_ext;
   logic [IW-1:0]             idx_addr;
   logic                      idx_ok;
   logic [IW-1:0]             push_addr;
   logic [UW+HANDLE_W-1:0]    used_ext4;
   logic [IW+HANDLE_W-1:0]    scan_ext4;
   logic                      full;
   logic [TIME_W-1:0]         rd_int_eff, rd_last_eff, due_sum;
   logic                      fire, hold, scan_end;
   logic [IW:0]               scan_nxt;
   logic [FIRE_CNT_W-1:0]     fcnt_nxt;
   logic [RATE_W-1:0]         divisor;
   logic [RATE_W:0]           div_shift;
   logic                      div_ge;
   logic [TIME_W-1:0]         mul_b, mul_res;

   assign accept     = req_tvalid & req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign req_idx    = req_tdata[HANDLE_W-1:0];
   assign req_value  = req_tdata[HANDLE_W+TIME_W-1:HANDLE_W];

   assign idx_ext   = {{IW{1'b0}}, req_idx};
   assign idx_addr  = idx_ext[IW-1:0];
   assign idx_ok    = idx_ext < (IW+HANDLE_W)'(MAX_TASKS);
   assign push_addr = used_ff[IW-1:0];
   assign used_ext4 = {{HANDLE_W{1'b0}}, used_ff};
   assign scan_ext4 = {{HANDLE_W{1'b0}}, scan_ff};
   assign full      = (used_ff == UW'(MAX_TASKS));

   assign rd_int_eff  = rd_ivld_ff ? rd_int_ff : '0;
   assign rd_last_eff = rd_lvld_ff ? rd_last_ff : '0;
   assign due_sum     = rd_last_eff + rd_int_eff;
   assign fire        = en_ff[scan_ff] & (tick_ff >= due_sum);
   assign hold        = fire & pend_valid_ff & ~out_free;
   assign scan_nxt    = {1'b0, scan_ff} + (IW+1)'(1);
   assign fcnt_nxt    = fcnt_ff + FIRE_CNT_W'(fire);
   assign scan_end    = (scan_nxt >= (IW+1)'(used_ff)) ||
                        (fcnt_nxt == FIRE_CNT_W'(FIRE_LIMIT));

   assign divisor   = (rate_ff == '0) ? RATE_W'(1) : rate_ff;
   assign div_shift = {div_rem_ff[RATE_W-1:0], div_quo_ff[TIME_W-1]};
   assign div_ge    = div_shift >= {1'b0, divisor};
   assign mul_b     = div_us_ff ? tick_ff : MS_SCALE;
   assign mul_res   = div_quo_ff * mul_b;

   assign rate_in      = csr_wr_en ? csr_wr_data : rate_ff;
   assign rsp_valid_in = out_load | (rsp_valid_ff & ~rsp_tready);

   always_comb begin
      state_in      = state_ff;
      tick_in       = tick_ff;
      used_in       = used_ff;
      en_in         = en_ff;
      ivld_in       = ivld_ff;
      lvld_in       = lvld_ff;
      scan_in       = scan_ff;
      fcnt_in       = fcnt_ff;
      div_rem_in    = div_rem_ff;
      div_quo_in    = div_quo_ff;
      div_cnt_in    = div_cnt_ff;
      div_us_in     = div_us_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_idx_in   = pend_idx_ff;
      pend_time_in  = pend_time_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      iw_en         = 1'b0;
      iw_addr       = idx_addr;
      lw_en         = 1'b0;
      lw_addr       = idx_addr;
      out_load      = 1'b0;
      out_last      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_tuser)
                  CMD_TICK: begin
                     tick_in = tick_ff + TIME_W'(1);
                     if (used_ff != '0) begin
                        scan_in  = '0;
                        fcnt_in  = '0;
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_PUSH, CMD_PUSH_EN: begin
                     pend_valid_in = 1'b1;
                     pend_time_in  = '0;
                     if (full) begin
                        pend_kind_in = KIND_FULL;
                        pend_idx_in  = '0;
                     end else begin
                        iw_en              = 1'b1;
                        iw_addr            = push_addr;
                        ivld_in[push_addr] = 1'b1;
                        lw_en              = 1'b1;
                        lw_addr            = push_addr;
                        lvld_in[push_addr] = 1'b1;
                        if (req_tuser == CMD_PUSH_EN) begin
                           en_in[push_addr] = 1'b1;
                        end
                        used_in      = used_ff + UW'(1);
                        pend_kind_in = KIND_HANDLE;
                        pend_idx_in  = used_ext4[HANDLE_W-1:0];
                     end
                     state_in = ST_FLUSH;
                  end
                  CMD_POP: begin
                     if (used_ff != '0) begin
                        used_in = used_ff - UW'(1);
                     end
                  end
                  CMD_START: begin
                     if (idx_ok) begin
                        lw_en             = 1'b1;
                        lvld_in[idx_addr] = 1'b1;
                        en_in[idx_addr]   = 1'b1;
                     end
                  end
                  CMD_STOP: begin
                     if (idx_ok) begin
                        en_in[idx_addr] = 1'b0;
                     end
                  end
                  CMD_TOGGLE: begin
                     if (idx_ok) begin
                        en_in[idx_addr] = ~en_ff[idx_addr];
                     end
                  end
                  CMD_SET_INT: begin
                     if (idx_ok) begin
                        iw_en             = 1'b1;
                        ivld_in[idx_addr] = 1'b1;
                     end
                  end
                  CMD_SET_RAW: begin
                     tick_in = req_value;
                  end
                  CMD_READ_RAW: begin
                     pend_valid_in = 1'b1;
                     pend_kind_in  = KIND_TIME;
                     pend_idx_in   = '0;
                     pend_time_in  = tick_ff;
                     state_in      = ST_FLUSH;
                  end
                  CMD_READ_MS, CMD_READ_US: begin
                     div_us_in  = (req_tuser == CMD_READ_US);
                     div_quo_in = (req_tuser == CMD_READ_US) ? US_SCALE : tick_ff;
                     div_rem_in = '0;
                     div_cnt_in = '0;
                     state_in   = ST_DIV;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!hold) begin
               if (fire) begin
                  lw_en            = 1'b1;
                  lw_addr          = scan_ff;
                  lvld_in[scan_ff] = 1'b1;
                  fcnt_in          = fcnt_nxt;
                  out_load         = pend_valid_ff;
                  pend_valid_in    = 1'b1;
                  pend_kind_in     = KIND_FIRED;
                  pend_idx_in      = scan_ext4[HANDLE_W-1:0];
                  pend_time_in     = tick_ff;
               end
               if (scan_end) begin
                  state_in = ST_FLUSH;
               end else begin
                  scan_in = scan_nxt[IW-1:0];
                  rd_en   = 1'b1;
                  rd_addr = scan_nxt[IW-1:0];
               end
            end
         end
         ST_DIV: begin
            div_rem_in = div_ge ? (div_shift - {1'b0, divisor}) : div_shift;
            div_quo_in = {div_quo_ff[TIME_W-2:0], div_ge};
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == '1) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            pend_valid_in = 1'b1;
            pend_kind_in  = KIND_TIME;
            pend_idx_in   = '0;
            pend_time_in  = mul_res;
            state_in      = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_load      = 1'b1;
               out_last      = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (iw_en) begin
         int_mem[iw_addr] <= req_value;
      end
      if (rd_en) begin
         rd_int_ff  <= int_mem[rd_addr];
         rd_ivld_ff <= ivld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (lw_en) begin
         last_mem[lw_addr] <= tick_ff;
      end
      if (rd_en) begin
         rd_last_ff <= last_mem[rd_addr];
         rd_lvld_ff <= lvld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tick_ff       <= '0;
         used_ff       <= '0;
         en_ff         <= '0;
         ivld_ff       <= '0;
         lvld_ff       <= '0;
         rate_ff       <= RATE_RESET;
         scan_ff       <= '0;
         fcnt_ff       <= '0;
         div_cnt_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         used_ff       <= used_in;
         en_ff         <= en_in;
         ivld_ff       <= ivld_in;
         lvld_ff       <= lvld_in;
         rate_ff       <= rate_in;
         scan_ff       <= scan_in;
         fcnt_ff       <= fcnt_in;
         div_cnt_ff    <= div_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      div_us_ff    <= div_us_in;
      pend_kind_ff <= pend_kind_in;
      pend_idx_ff  <= pend_idx_in;
      pend_time_ff <= pend_time_in;
      if (out_load) begin
         rsp_kind_ff <= pend_kind_ff;
         rsp_idx_ff  <= pend_idx_ff;
         rsp_time_ff <= pend_time_ff;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(DATA_W-HANDLE_W-TIME_W){1'b0}}, rsp_time_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A result beat is only loaded into a free output register.
   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free) else $error("result register overwritten");

   // The slot stack never grows past the table size.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(MAX_TASKS)) else $error("slot count out of range");

   // No result may be left behind when a new command is taken.
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff) else $error("pending result in idle");

   // An accepted push into a table with room grows the stack by one slot.
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser == CMD_PUSH || req_tuser == CMD_PUSH_EN) && !full)
      |=> (used_ff == $past(used_ff) + UW'(1))) else $error("push did not add a slot");

endmodule
